/* design/aclm_pkg.sv */
// aclm_pkg: shared types and constants for the addressed command line matcher
// no dependencies; used by addressed_command_line_matcher_core

package aclm_pkg;

    localparam int ByteW     = 8;
    localparam int WordW     = 64;
    localparam int IdLenW    = 4;
    localparam int CmdCountW = 3;
    localparam int SlotW     = 2;
    localparam int CfgIndexW = 3;

    localparam logic [ByteW-1:0] LINE_END = 8'h0A;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_DEVICE_ID_WORD   = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_DEVICE_ID_LENGTH = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_COMMAND_COUNT    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_NAME_SLOT_0      = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_NAME_SLOT_1      = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_NAME_SLOT_2      = 3'd5;
    localparam logic [CfgIndexW-1:0] CFG_NAME_SLOT_3      = 3'd6;

    // result kinds carried on m_tuser
    localparam logic OUTCOME_MATCH = 1'b0;
    localparam logic OUTCOME_NAK   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ID   = 3'b010,
        PH_MSG  = 3'b100
    } phase_t;

endpackage

/* design/addressed_command_line_matcher_core.sv */
// addressed_command_line_matcher_core: device prefix check, message gathering
// and command name lookup on a byte stream; depends on aclm_pkg
//
// result path: the input transaction is held in the input register, then the result in the result register
// throughput: one byte per cycle; input stalls only while a result waits for m_tready
// reset: synchronous, active low; phase idle, counts and message cleared,
// prefix length 1, command count 0, prefix word and names zero

module addressed_command_line_matcher_core #(
    parameter int MESSAGE_BYTES = 8,
    parameter int COMMAND_SLOTS = 4,
    parameter int ID_BYTES      = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [aclm_pkg::ByteW-1:0]           s_tdata,   // [7:0] byte_in
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // [1:0] matched_slot, [7:2] zero
    output logic                                 m_tuser,   // [0] outcome
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [aclm_pkg::CfgIndexW-1:0]       cfg_index,
    input  logic [aclm_pkg::WordW-1:0]           cfg_wdata
);

    localparam int MsgW = MESSAGE_BYTES * aclm_pkg::ByteW;
    localparam int LenW = $clog2(MESSAGE_BYTES + 1);
    localparam int CntW = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

    // configuration
    logic [aclm_pkg::WordW-1:0]     dev_id_reg;
    logic [aclm_pkg::IdLenW-1:0]    dev_len_reg;
    logic [aclm_pkg::CmdCountW-1:0] cmd_count_reg;
    logic [aclm_pkg::WordW-1:0]     name_slot_reg [COMMAND_SLOTS];

    // input register
    logic                       in_valid_reg;
    logic [aclm_pkg::ByteW-1:0] in_byte_reg;

    // parse state
    aclm_pkg::phase_t phase_reg, phase_next;
    logic [CntW-1:0]  id_cnt_reg, id_cnt_next;
    logic [MsgW-1:0]  msg_reg, msg_next;
    logic [LenW-1:0]  msg_len_reg, msg_len_next;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic                      m_outcome_reg, m_outcome_next;
    logic [aclm_pkg::SlotW-1:0] m_slot_reg, m_slot_next;

    logic                          advance;
    logic                          step;
    logic [CntW-1:0]               cur_cnt;
    logic [aclm_pkg::ByteW-1:0]    id_byte;
    logic [aclm_pkg::IdLenW-1:0]   prefix_len;
    logic [aclm_pkg::IdLenW-1:0]   cnt_plus;
    logic [aclm_pkg::CmdCountW-1:0] used_slots;
    logic                          hit;
    logic [aclm_pkg::SlotW-1:0]    hit_slot;
    logic                          result_load;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_outcome_reg;
    assign m_tdata  = {{(8 - aclm_pkg::SlotW){1'b0}}, m_slot_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_id_reg    <= '0;
            dev_len_reg   <= aclm_pkg::IdLenW'(1);
            cmd_count_reg <= '0;
            for (int k = 0; k < COMMAND_SLOTS; k++) begin
                name_slot_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                aclm_pkg::CFG_DEVICE_ID_WORD: begin
                    dev_id_reg <= cfg_wdata;
                end
                aclm_pkg::CFG_DEVICE_ID_LENGTH: begin
                    dev_len_reg <= cfg_wdata[aclm_pkg::IdLenW-1:0];
                end
                aclm_pkg::CFG_COMMAND_COUNT: begin
                    cmd_count_reg <= cfg_wdata[aclm_pkg::CmdCountW-1:0];
                end
                aclm_pkg::CFG_NAME_SLOT_0, aclm_pkg::CFG_NAME_SLOT_1,
                aclm_pkg::CFG_NAME_SLOT_2, aclm_pkg::CFG_NAME_SLOT_3: begin
                    for (int k = 0; k < COMMAND_SLOTS; k++) begin
                        if (cfg_index == aclm_pkg::CFG_NAME_SLOT_0 + aclm_pkg::CfgIndexW'(k)) begin
                            name_slot_reg[k] <= cfg_wdata;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // prefix byte and effective limits
    always_comb begin
        cur_cnt = (phase_reg == aclm_pkg::PH_ID) ? id_cnt_reg : '0;
        id_byte = dev_id_reg[{3'(cur_cnt), 3'b000} +: aclm_pkg::ByteW];
        cnt_plus = aclm_pkg::IdLenW'(cur_cnt) + aclm_pkg::IdLenW'(1);
        if (dev_len_reg == '0) begin
            prefix_len = aclm_pkg::IdLenW'(1);
        end else if (dev_len_reg > aclm_pkg::IdLenW'(ID_BYTES)) begin
            prefix_len = aclm_pkg::IdLenW'(ID_BYTES);
        end else begin
            prefix_len = dev_len_reg;
        end
        if (cmd_count_reg > aclm_pkg::CmdCountW'(COMMAND_SLOTS)) begin
            used_slots = aclm_pkg::CmdCountW'(COMMAND_SLOTS);
        end else begin
            used_slots = cmd_count_reg;
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int k = COMMAND_SLOTS - 1; k >= 0; k--) begin
            if (aclm_pkg::CmdCountW'(k) < used_slots
                && name_slot_reg[k] == aclm_pkg::WordW'(msg_reg)) begin
                hit      = 1'b1;
                hit_slot = aclm_pkg::SlotW'(k);
            end
        end
    end

    // parse step
    always_comb begin
        phase_next     = phase_reg;
        id_cnt_next    = id_cnt_reg;
        msg_next       = msg_reg;
        msg_len_next   = msg_len_reg;
        result_load    = 1'b0;
        m_outcome_next = m_outcome_reg;
        m_slot_next    = m_slot_reg;
        if (step) begin
            unique case (phase_reg)
                aclm_pkg::PH_MSG: begin
                    if (in_byte_reg == aclm_pkg::LINE_END) begin
                        result_load    = 1'b1;
                        m_outcome_next = hit ? aclm_pkg::OUTCOME_MATCH : aclm_pkg::OUTCOME_NAK;
                        m_slot_next    = hit_slot;
                        phase_next     = aclm_pkg::PH_IDLE;
                        id_cnt_next    = '0;
                        msg_next       = '0;
                        msg_len_next   = '0;
                    end else if (msg_len_reg < LenW'(MESSAGE_BYTES)) begin
                        for (int i = 0; i < MESSAGE_BYTES; i++) begin
                            if (msg_len_reg == LenW'(i)) begin
                                msg_next[i*aclm_pkg::ByteW +: aclm_pkg::ByteW] = in_byte_reg;
                            end
                        end
                        msg_len_next = msg_len_reg + LenW'(1);
                    end else begin
                        phase_next   = aclm_pkg::PH_IDLE;
                        id_cnt_next  = '0;
                        msg_next     = '0;
                        msg_len_next = '0;
                    end
                end
                default: begin
                    msg_next     = '0;
                    msg_len_next = '0;
                    if (in_byte_reg != id_byte) begin
                        phase_next  = aclm_pkg::PH_IDLE;
                        id_cnt_next = '0;
                    end else if (cnt_plus >= prefix_len) begin
                        phase_next  = aclm_pkg::PH_MSG;
                        id_cnt_next = '0;
                    end else begin
                        phase_next  = aclm_pkg::PH_ID;
                        id_cnt_next = CntW'(cnt_plus);
                    end
                end
            endcase
        end
        if (advance) begin
            m_valid_next = result_load;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= aclm_pkg::PH_IDLE;
            id_cnt_reg  <= '0;
            msg_reg     <= '0;
            msg_len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            id_cnt_reg  <= id_cnt_next;
            msg_reg     <= msg_next;
            msg_len_reg <= msg_len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_outcome_reg <= m_outcome_next;
            m_slot_reg    <= m_slot_next;
        end
    end

    // checks
    a_result_from_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |-> phase_reg == aclm_pkg::PH_MSG)
        else $error("result raised outside message phase");

    a_msg_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        msg_len_reg <= LenW'(MESSAGE_BYTES))
        else $error("message length beyond buffer");

    a_msg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != aclm_pkg::PH_MSG |-> msg_len_reg == '0 && msg_reg == '0)
        else $error("message held outside message phase");

    a_id_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == aclm_pkg::PH_ID
            |-> id_cnt_reg != '0
                && aclm_pkg::IdLenW'(id_cnt_reg) < aclm_pkg::IdLenW'(ID_BYTES))
        else $error("prefix count out of range");

    a_nak_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_outcome_reg == aclm_pkg::OUTCOME_NAK |-> m_slot_reg == '0)
        else $error("nak with non-zero slot");

endmodule

/* tb/addressed_command_line_matcher_core_tb.sv */
`timescale 1ns / 100ps
// addressed_command_line_matcher_core_tb: self-checking bench for the command line matcher
// drives prefixed command lines and noise, predicts match/nak results; depends on aclm_pkg

module addressed_command_line_matcher_core_tb;

    localparam int MSG_BYTES   = 8;
    localparam int NAME_SLOTS  = 4;
    localparam int PREFIX_MAX  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1000;
    localparam logic [aclm_pkg::CfgIndexW-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic       outcome;
        logic [1:0] slot;
    } line_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [aclm_pkg::ByteW-1:0]     s_tdata;    // [7:0] byte_in
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;    // [1:0] matched_slot, [7:2] zero
    logic                           m_tuser;    // [0] outcome
    logic                           cfg_we;
    logic [aclm_pkg::CfgIndexW-1:0] cfg_index;
    logic [aclm_pkg::WordW-1:0]     cfg_wdata;

    // mirrored registers
    logic [63:0] id_word;
    logic [3:0]  id_len;
    logic [2:0]  cmd_count;
    logic [63:0] names [NAME_SLOTS];

    // predicted parser state
    aclm_pkg::phase_t parse_ph;
    logic [3:0]  id_matched;
    logic [63:0] msg_word;
    logic [3:0]  msg_len;

    line_result_t pending_results[$];
    line_result_t seen_want;
    int error_count = 0;
    int cycle_count = 0;
    int sent_count  = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;

    addressed_command_line_matcher_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int prefix_bytes();
        int n;
        n = id_len;
        if (n == 0) n = 1;
        if (n > PREFIX_MAX) n = PREFIX_MAX;
        return n;
    endfunction

    function automatic int slots_in_use();
        int n;
        n = cmd_count;
        if (n > NAME_SLOTS) n = NAME_SLOTS;
        return n;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == aclm_pkg::LINE_END) b = 8'h0B;
        return b;
    endfunction

    function automatic logic [63:0] random_name();
        logic [63:0] w;
        int n;
        w = '0;
        n = $urandom_range(0, MSG_BYTES);
        for (int i = 0; i < n; i++) begin
            w[i*8 +: 8] = ($urandom_range(0, 7) == 0) ? 8'h00 : text_byte();
        end
        return w;
    endfunction

    task automatic parser_to_idle();
        parse_ph   = aclm_pkg::PH_IDLE;
        id_matched = '0;
        msg_word   = '0;
        msg_len    = '0;
    endtask

    task automatic check_prefix_byte(input logic [7:0] b);
        if (b != id_word[id_matched[2:0]*8 +: 8]) begin
            parser_to_idle();
        end else begin
            id_matched = id_matched + 1'b1;
            if (int'(id_matched) >= prefix_bytes()) begin
                parse_ph = aclm_pkg::PH_MSG;
                msg_word = '0;
                msg_len  = '0;
            end else begin
                parse_ph = aclm_pkg::PH_ID;
            end
        end
    endtask

    // advances the predicted parser by one byte, queues a result on a line end
    task automatic match_byte(input logic [7:0] b);
        line_result_t r;
        if (parse_ph == aclm_pkg::PH_MSG) begin
            if (b == aclm_pkg::LINE_END) begin
                r.outcome = aclm_pkg::OUTCOME_NAK;
                r.slot    = '0;
                for (int k = 0; k < slots_in_use(); k++) begin
                    if (names[k] == msg_word) begin
                        r.outcome = aclm_pkg::OUTCOME_MATCH;
                        r.slot    = 2'(k);
                        break;
                    end
                end
                pending_results.push_back(r);
                parser_to_idle();
            end else if (msg_len < MSG_BYTES) begin
                msg_word[msg_len*8 +: 8] = b;
                msg_len = msg_len + 1'b1;
            end else begin
                parser_to_idle();
            end
        end else if (parse_ph == aclm_pkg::PH_ID) begin
            check_prefix_byte(b);
        end else begin
            id_matched = '0;
            check_prefix_byte(b);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) tx_calm = $urandom_range(10, 40);
            gap = $urandom_range(0, 11);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        match_byte(b);
        sent_count++;
    endtask

    task automatic send_packed(input logic [255:0] bytes_w, input int count);
        for (int i = 0; i < count; i++) send_byte(bytes_w[i*8 +: 8]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [aclm_pkg::CfgIndexW-1:0] idx,
                             input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            aclm_pkg::CFG_DEVICE_ID_WORD:   id_word   = val;
            aclm_pkg::CFG_DEVICE_ID_LENGTH: id_len    = val[3:0];
            aclm_pkg::CFG_COMMAND_COUNT:    cmd_count = val[2:0];
            aclm_pkg::CFG_NAME_SLOT_0:      names[0]  = val;
            aclm_pkg::CFG_NAME_SLOT_1:      names[1]  = val;
            aclm_pkg::CFG_NAME_SLOT_2:      names[2]  = val;
            aclm_pkg::CFG_NAME_SLOT_3:      names[3]  = val;
            default: ;
        endcase
    endtask

    // upper write data bits are noise, only the register width counts
    task automatic apply_settings(input logic [63:0] idw, input logic [3:0] len,
                                  input logic [2:0] count, input logic [63:0] n0,
                                  input logic [63:0] n1, input logic [63:0] n2,
                                  input logic [63:0] n3);
        drain();
        cfg_write(aclm_pkg::CFG_DEVICE_ID_WORD, idw);
        cfg_write(aclm_pkg::CFG_DEVICE_ID_LENGTH, ({$urandom(), $urandom()} & ~64'hF) | len);
        cfg_write(aclm_pkg::CFG_COMMAND_COUNT, ({$urandom(), $urandom()} & ~64'h7) | count);
        cfg_write(aclm_pkg::CFG_NAME_SLOT_0, n0);
        cfg_write(aclm_pkg::CFG_NAME_SLOT_1, n1);
        cfg_write(aclm_pkg::CFG_NAME_SLOT_2, n2);
        cfg_write(aclm_pkg::CFG_NAME_SLOT_3, n3);
        cfg_write(CFG_UNUSED, {$urandom(), $urandom()});
        cfg_we <= 1'b0;
    endtask

    // one line: prefix (sometimes broken), message, usually a line end; or plain noise
    task automatic send_frame();
        logic [255:0] f;
        logic [63:0]  name;
        int n, kind, plen, bad_pos, pick, last_nz, msg_n;
        f    = '0;
        n    = 0;
        kind = $urandom_range(0, 9);
        plen = prefix_bytes();
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) f[i*8 +: 8] = 8'($urandom_range(0, 255));
        end else begin
            bad_pos = (kind == 1) ? $urandom_range(0, plen - 1) : plen;
            for (int i = 0; i < plen && i <= bad_pos; i++) begin
                f[n*8 +: 8] = id_word[i*8 +: 8];
                if (i == bad_pos) f[n*8 +: 8] ^= 8'($urandom_range(1, 255));
                n++;
            end
            pick = $urandom_range(0, 5);
            if (pick < NAME_SLOTS) begin
                name = names[pick];
                last_nz = 0;
                for (int i = 0; i < MSG_BYTES; i++) if (name[i*8 +: 8] != 0) last_nz = i + 1;
                msg_n = $urandom_range(last_nz, MSG_BYTES);
                for (int i = 0; i < msg_n; i++) begin
                    f[n*8 +: 8] = name[i*8 +: 8];
                    n++;
                end
            end else begin
                msg_n = (pick == 4) ? $urandom_range(0, MSG_BYTES)
                                    : $urandom_range(MSG_BYTES + 1, MSG_BYTES + 2);
                for (int i = 0; i < msg_n; i++) begin
                    f[n*8 +: 8] = text_byte();
                    n++;
                end
            end
            if ($urandom_range(0, 15) != 0) begin
                f[n*8 +: 8] = aclm_pkg::LINE_END;
                n++;
            end
        end
        send_packed(f, n);
    endtask

    task automatic test_reset_values();
        // prefix 0x00 of length one, no names in use: empty line is a nak
        send_packed({aclm_pkg::LINE_END, 8'h00}, 2);
        send_byte(8'h41);
    endtask

    task automatic test_directed_lines();
        apply_settings(64'h00000000000000FF, 4'd1, 3'd4,
                       64'h0, 64'h4F47, 64'hFF0000, 64'h4F47);
        send_packed({aclm_pkg::LINE_END, 8'hFF}, 2);                  // empty message, zero slot
        send_packed({aclm_pkg::LINE_END, 8'h4F, 8'h47, 8'hFF}, 4);    // lowest equal slot wins
        send_packed({aclm_pkg::LINE_END, 8'hFF, 8'h00, 8'h00, 8'hFF}, 5); // zero bytes
        send_packed({aclm_pkg::LINE_END, 8'h58, 8'hFF}, 3);           // unknown command
        send_byte(8'h7E);                                             // prefix mismatch
        send_packed({8'h01, 8'h7F, 8'h80, 8'hFE, 8'h55, 8'hAA, 8'h00, 8'h33,
                     8'h22, 8'hFF}, 10);                              // message too long
    endtask

    task automatic test_random_lines();
        int phase_end;
        for (int s = 0; s < 8; s++) begin
            case (s)
                0: apply_settings({$urandom(), $urandom()}, 4'd1, 3'd4,
                                  random_name(), random_name(), random_name(), random_name());
                1: apply_settings({$urandom(), $urandom()}, 4'd8, 3'd4,
                                  random_name(), random_name(), random_name(), random_name());
                2: apply_settings({$urandom(), $urandom()}, 4'd0, 3'd7,
                                  random_name(), random_name(), 64'h0, random_name());
                3: apply_settings({$urandom(), $urandom()}, 4'd15, 3'd0,
                                  random_name(), random_name(), random_name(), random_name());
                4: apply_settings({64{1'b1}}, 4'd9, 3'd5,
                                  {64{1'b1}}, random_name(), random_name(), 64'h0);
                5: apply_settings(64'h0, 4'($urandom_range(1, 8)), 3'($urandom_range(0, 4)),
                                  random_name(), random_name(), random_name(), random_name());
                default: apply_settings({$urandom(), $urandom()}, 4'($urandom_range(0, 15)),
                                        3'($urandom_range(0, 7)), random_name(),
                                        random_name(), random_name(), random_name());
            endcase
            phase_end = sent_count + RANDOM_ITEMS / 8;
            while (sent_count < phase_end) send_frame();
        end
    endtask

    // result side: random stalls with calm stretches
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            if (rx_calm > 0) begin
                rx_calm--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) rx_calm = $urandom_range(10, 40);
                stall = $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: outcome %0b tdata %02h", m_tuser, m_tdata);
            end else begin
                seen_want = pending_results.pop_front();
                if (m_tuser !== seen_want.outcome || m_tdata !== {6'b0, seen_want.slot}) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result mismatch: expected outcome %0b slot %0d, %s %0b %s %02h",
                                 seen_want.outcome, seen_want.slot, "got", m_tuser,
                                 "tdata", m_tdata);
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        id_word   = '0;
        id_len    = 4'd1;
        cmd_count = '0;
        for (int k = 0; k < NAME_SLOTS; k++) names[k] = '0;
        parser_to_idle();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_directed_lines();
        test_random_lines();

        drain();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) error_count++;
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
